// File: hdl/wse_pkg.sv
`default_nettype none

package wse_pkg;

    localparam int MAX_WINDOW = 32;
    localparam int IDX_W = $clog2(MAX_WINDOW);
    localparam int CNT_W = $clog2(MAX_WINDOW + 1);
    localparam int SPD_W = 32;
    localparam int SUM_W = SPD_W + $clog2(MAX_WINDOW);
    localparam int Q_W = 48;
    localparam int REM_W = 48;
    localparam int MUL_W = REM_W + 10;
    localparam int NUM_W = MUL_W + 16;
    localparam int AVG_STEPS = SUM_W + 16;
    localparam int DCNT_W = $clog2(NUM_W + 1);
    localparam int ETA_W = 63;
    localparam int ALPHA_W = 17;
    localparam int WL_W = 6;
    localparam int OP_W = 2;
    localparam int CFG_W = 17;

    localparam logic [ALPHA_W-1:0] ONE_Q16 = ALPHA_W'(65536);
    localparam logic [ALPHA_W-1:0] ALPHA_RESET = ALPHA_W'(6554);
    localparam logic [WL_W-1:0] WL_RESET = WL_W'(MAX_WINDOW);

    localparam logic [OP_W-1:0] OP_PUSH = 2'd0;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;

    localparam logic CFG_WINDOW = 1'b0;
    localparam logic CFG_ALPHA = 1'b1;

    typedef struct packed {
        logic capture;
        logic push_rd;
        logic push_upd;
        logic clear;
        logic res_empty;
        logic avg_start;
        logic div_step;
        logic avg_take;
        logic walk_rd;
        logic walk_mul;
        logic walk_acc;
        logic eta_start;
        logic eta_unknown;
        logic eta_take;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic fill_zero;
        logic div_last;
        logic walk_last;
        logic eta_none;
    } stat_t;

endpackage

`default_nettype wire

// File: hdl/wse_ctrl.sv
`default_nettype none

module wse_ctrl
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [wse_pkg::OP_W-1:0] opcode,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    input  wire wse_pkg::stat_t         stat,
    output wse_pkg::cmd_t               cmd
);

    typedef enum logic [12:0] {
        S_IDLE     = 13'b0000000000001,
        S_PUSH_RD  = 13'b0000000000010,
        S_PUSH_UPD = 13'b0000000000100,
        S_CLEAR    = 13'b0000000001000,
        S_CHECK    = 13'b0000000010000,
        S_AVG_DIV  = 13'b0000000100000,
        S_AVG_END  = 13'b0000001000000,
        S_W_RD     = 13'b0000010000000,
        S_W_MUL    = 13'b0000100000000,
        S_W_ACC    = 13'b0001000000000,
        S_ETA_CHK  = 13'b0010000000000,
        S_ETA_DIV  = 13'b0100000000000,
        S_DONE     = 13'b1000000000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_tvalid_reg;
    logic   m_tvalid_next;
    logic   out_free;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    if (opcode == wse_pkg::OP_PUSH)
                        state_next = S_PUSH_RD;
                    else if (opcode == wse_pkg::OP_CLEAR)
                        state_next = S_CLEAR;
                    else
                        state_next = S_CHECK;
                end
            end
            S_PUSH_RD:
            begin
                cmd.push_rd = 1'b1;
                state_next = S_PUSH_UPD;
            end
            S_PUSH_UPD:
            begin
                cmd.push_upd = 1'b1;
                state_next = S_CHECK;
            end
            S_CLEAR:
            begin
                cmd.clear = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (stat.fill_zero)
                begin
                    cmd.res_empty = 1'b1;
                    cmd.eta_unknown = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.avg_start = 1'b1;
                    state_next = S_AVG_DIV;
                end
            end
            S_AVG_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                    state_next = S_AVG_END;
            end
            S_AVG_END:
            begin
                cmd.avg_take = 1'b1;
                state_next = S_W_RD;
            end
            S_W_RD:
            begin
                cmd.walk_rd = 1'b1;
                state_next = S_W_MUL;
            end
            S_W_MUL:
            begin
                cmd.walk_mul = 1'b1;
                state_next = S_W_ACC;
            end
            S_W_ACC:
            begin
                cmd.walk_acc = 1'b1;
                state_next = stat.walk_last ? S_ETA_CHK : S_W_RD;
            end
            S_ETA_CHK:
            begin
                if (stat.eta_none)
                begin
                    cmd.eta_unknown = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.eta_start = 1'b1;
                    state_next = S_ETA_DIV;
                end
            end
            S_ETA_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    cmd.eta_take = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

`default_nettype wire

// File: hdl/wse_dp.sv
`default_nettype none

module wse_dp
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire wse_pkg::cmd_t               cmd,
    output wse_pkg::stat_t                   stat,
    input  wire logic                        cfg_we,
    input  wire logic                        cfg_addr,
    input  wire logic [wse_pkg::CFG_W-1:0]   cfg_data,
    input  wire logic [wse_pkg::SPD_W-1:0]   sample_speed,
    input  wire logic [wse_pkg::REM_W-1:0]   remaining_bytes,
    output logic [wse_pkg::Q_W-1:0]          average_speed,
    output logic [wse_pkg::Q_W-1:0]          smoothed_speed,
    output logic [wse_pkg::SPD_W-1:0]        current_speed,
    output logic [wse_pkg::ETA_W-1:0]        eta_ms,
    output logic [wse_pkg::CNT_W-1:0]        sample_count
);

    localparam int IW = wse_pkg::IDX_W;
    localparam int CW = wse_pkg::CNT_W;
    localparam int SW = wse_pkg::SPD_W;
    localparam int QW = wse_pkg::Q_W;
    localparam int NW = wse_pkg::NUM_W;
    localparam int AW = wse_pkg::ALPHA_W;
    localparam logic [wse_pkg::ETA_W-1:0] ETA_MAX = {1'b0, {(wse_pkg::ETA_W-1){1'b1}}};

    logic [SW-1:0] ring [wse_pkg::MAX_WINDOW];
    logic [SW-1:0] rd_data_reg;
    logic [IW-1:0] rd_addr;
    logic [IW-1:0] slot;

    logic [IW-1:0] oldest_reg;
    logic [CW-1:0] fill_reg;
    logic [wse_pkg::SUM_W-1:0] sum_reg;
    logic [wse_pkg::WL_W-1:0] wl_reg;
    logic [AW-1:0] alpha_reg;

    logic [SW-1:0] sample_reg;
    logic [wse_pkg::REM_W-1:0] remain_reg;

    logic [CW-1:0] eff_len;
    logic          drop;
    logic [AW-1:0] alpha_eff;
    logic [AW-1:0] alpha_inv;

    logic [IW-1:0] k_reg;
    logic [QW+SW-1:0] p1_reg;
    logic [QW:0]      p2_reg;
    logic [QW+AW-1:0] p2_full;
    logic [QW+1:0]    smooth_sum;
    logic [QW-1:0]    smooth_reg;

    logic [NW-1:0] num_reg;
    logic [QW-1:0] dvs_reg;
    logic [QW-1:0] drem_reg;
    logic [NW-1:0] quo_reg;
    logic [NW-1:0] quo_shift;
    logic [wse_pkg::DCNT_W-1:0] dcnt_reg;
    logic [QW:0]   trial;
    logic          ge;
    logic [wse_pkg::MUL_W-1:0] rem1000;

    logic [QW-1:0] avg_res_reg;
    logic [SW-1:0] cur_res_reg;
    logic [wse_pkg::ETA_W-1:0] eta_res_reg;

    logic [QW-1:0] out_avg_reg;
    logic [QW-1:0] out_smooth_reg;
    logic [SW-1:0] out_cur_reg;
    logic [wse_pkg::ETA_W-1:0] out_eta_reg;
    logic [CW-1:0] out_cnt_reg;

    always_comb
    begin
        if (wl_reg == '0)
            eff_len = CW'(1);
        else if (CW'(wl_reg) > CW'(wse_pkg::MAX_WINDOW))
            eff_len = CW'(wse_pkg::MAX_WINDOW);
        else
            eff_len = CW'(wl_reg);
    end

    assign drop = (fill_reg >= eff_len);
    assign slot = oldest_reg + fill_reg[IW-1:0];
    assign rd_addr = cmd.push_rd ? oldest_reg : oldest_reg + k_reg;
    assign alpha_eff = (alpha_reg > wse_pkg::ONE_Q16) ? wse_pkg::ONE_Q16 : alpha_reg;
    assign alpha_inv = wse_pkg::ONE_Q16 - alpha_eff;
    assign p2_full = alpha_inv * smooth_reg;
    assign smooth_sum = (QW+2)'(p1_reg) + (QW+2)'(p2_reg);
    assign trial = {drem_reg, num_reg[NW-1]};
    assign ge = (trial >= {1'b0, dvs_reg});
    assign quo_shift = {quo_reg[NW-2:0], ge};
    assign rem1000 = ({remain_reg, 10'b0}) - (wse_pkg::MUL_W'({remain_reg, 4'b0}))
        - (wse_pkg::MUL_W'({remain_reg, 3'b0}));

    assign stat.fill_zero = (fill_reg == '0);
    assign stat.div_last = (dcnt_reg == wse_pkg::DCNT_W'(1));
    assign stat.walk_last = ({1'b0, k_reg} == fill_reg - CW'(1));
    assign stat.eta_none = (smooth_reg == '0) || (remain_reg == '0);

    always_ff @(posedge clk)
    begin
        if (cmd.push_rd)
            ring[slot] <= sample_reg;
        if (cmd.push_rd || cmd.walk_rd)
            rd_data_reg <= ring[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oldest_reg <= '0;
            fill_reg <= '0;
            sum_reg <= '0;
            wl_reg <= wse_pkg::WL_RESET;
            alpha_reg <= wse_pkg::ALPHA_RESET;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    wse_pkg::CFG_WINDOW: wl_reg <= cfg_data[wse_pkg::WL_W-1:0];
                    wse_pkg::CFG_ALPHA:  alpha_reg <= cfg_data[AW-1:0];
                    default: ;
                endcase
            end
            if (cmd.push_upd)
            begin
                sum_reg <= sum_reg + wse_pkg::SUM_W'(sample_reg)
                    - (drop ? wse_pkg::SUM_W'(rd_data_reg) : '0);
                if (drop)
                    oldest_reg <= oldest_reg + IW'(1);
                else
                    fill_reg <= fill_reg + CW'(1);
            end
            if (cmd.clear)
            begin
                oldest_reg <= '0;
                fill_reg <= '0;
                sum_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            sample_reg <= sample_speed;
            remain_reg <= remaining_bytes;
        end
        if (cmd.res_empty)
        begin
            avg_res_reg <= '0;
            smooth_reg <= '0;
            cur_res_reg <= '0;
        end
        if (cmd.eta_unknown)
            eta_res_reg <= '1;
        if (cmd.avg_start)
        begin
            num_reg <= {sum_reg, (NW - wse_pkg::SUM_W)'(0)};
            dvs_reg <= QW'(fill_reg);
            drem_reg <= '0;
            quo_reg <= '0;
            dcnt_reg <= wse_pkg::DCNT_W'(wse_pkg::AVG_STEPS);
        end
        if (cmd.eta_start)
        begin
            num_reg <= {rem1000, 16'b0};
            dvs_reg <= smooth_reg;
            drem_reg <= '0;
            quo_reg <= '0;
            dcnt_reg <= wse_pkg::DCNT_W'(NW);
        end
        if (cmd.div_step)
        begin
            drem_reg <= ge ? QW'(trial - {1'b0, dvs_reg}) : QW'(trial);
            quo_reg <= quo_shift;
            num_reg <= {num_reg[NW-2:0], 1'b0};
            dcnt_reg <= dcnt_reg - wse_pkg::DCNT_W'(1);
        end
        if (cmd.avg_take)
        begin
            avg_res_reg <= quo_reg[QW-1:0];
            k_reg <= '0;
        end
        if (cmd.walk_mul)
        begin
            p1_reg <= alpha_eff * rd_data_reg;
            p2_reg <= p2_full[QW+AW-1:16];
            cur_res_reg <= rd_data_reg;
        end
        if (cmd.walk_acc)
        begin
            if (k_reg == '0)
                smooth_reg <= {rd_data_reg, 16'b0};
            else
                smooth_reg <= smooth_sum[QW-1:0];
            k_reg <= k_reg + IW'(1);
        end
        if (cmd.eta_take)
        begin
            if (quo_shift[NW-1:wse_pkg::ETA_W-1] != '0)
                eta_res_reg <= ETA_MAX;
            else
                eta_res_reg <= quo_shift[wse_pkg::ETA_W-1:0];
        end
        if (cmd.out_load)
        begin
            out_avg_reg <= avg_res_reg;
            out_smooth_reg <= smooth_reg;
            out_cur_reg <= cur_res_reg;
            out_eta_reg <= eta_res_reg;
            out_cnt_reg <= fill_reg;
        end
    end

    assign average_speed = out_avg_reg;
    assign smoothed_speed = out_smooth_reg;
    assign current_speed = out_cur_reg;
    assign eta_ms = out_eta_reg;
    assign sample_count = out_cnt_reg;

endmodule

`default_nettype wire

// File: hdl/windowed_speed_eta_estimator.sv
// Windowed speed and ETA estimator.
// Input words arrive on s_tvalid/s_tready/s_tdata/s_tuser: s_tuser carries the
// opcode (push, clear or query) and s_tdata the speed sample and remaining bytes.
// One result word per input word leaves on m_tvalid/m_tready/m_tdata.
// The block works on one word at a time. A push writes the ring memory and
// reads the oldest sample, then updates the running sum; the mean is then
// formed in the shared radix-2 divider, the smoothing walk reads, multiplies
// and accumulates each held sample through the ring read port and the two
// multipliers, and a known ETA takes a second pass through the divider. An empty
// window skips the divider and the walk. The configuration port (cfg_we, cfg_addr,
// cfg_data) must be written only while the block is idle, which the block does
// not enforce; index 0 is the window length and index 1 the smoothing weight.
// Reset empties the window and restores the default configuration.
// The result register holds a word while m_tready is low, and a new input word
// is taken meanwhile; the block waits before loading the next result until the
// held word has been taken.
`default_nettype none

module windowed_speed_eta_estimator
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [79:0]                 s_tdata,  // sample_speed, remaining_bytes
    input  wire logic [1:0]                  s_tuser,  // opcode
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    // average_speed, smoothed_speed, current_speed, eta_ms, sample_count, zero fill
    output logic [199:0]                     m_tdata,
    input  wire logic                        cfg_we,
    input  wire logic                        cfg_addr,
    input  wire logic [wse_pkg::CFG_W-1:0]   cfg_data
);

    wse_pkg::cmd_t  cmd;
    wse_pkg::stat_t stat;
    logic [wse_pkg::Q_W-1:0]   average_speed;
    logic [wse_pkg::Q_W-1:0]   smoothed_speed;
    logic [wse_pkg::SPD_W-1:0] current_speed;
    logic [wse_pkg::ETA_W-1:0] eta_ms;
    logic [wse_pkg::CNT_W-1:0] sample_count;

    wse_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .opcode   (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    wse_dp u_dp
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .cfg_we          (cfg_we),
        .cfg_addr        (cfg_addr),
        .cfg_data        (cfg_data),
        .sample_speed    (s_tdata[31:0]),
        .remaining_bytes (s_tdata[79:32]),
        .average_speed   (average_speed),
        .smoothed_speed  (smoothed_speed),
        .current_speed   (current_speed),
        .eta_ms          (eta_ms),
        .sample_count    (sample_count)
    );

    assign m_tdata = {3'b0, sample_count, eta_ms, current_speed, smoothed_speed,
                      average_speed};

`ifndef SYNTH
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while a word is in progress");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[196:191] <= 6'd32)
        else $error("sample count above window capacity");

    a_empty_eta: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[196:191] == 6'd0 |-> (&m_tdata[190:128]))
        else $error("empty window must report unknown ETA");
`endif

endmodule

`default_nettype wire

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps
`default_nettype none

module testbench;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] sample_speed;
        logic [47:0] remaining_bytes;
    } speed_word_t;

    typedef struct packed {
        logic [5:0]  sample_count;
        logic [62:0] eta_ms;
        logic [31:0] current_speed;
        logic [47:0] smoothed_speed;
        logic [47:0] average_speed;
    } estimate_t;

    localparam logic [1:0] OP_QUERY = 2'd2;
    localparam logic [1:0] OP_SPARE = 2'd3;
    localparam logic [62:0] ETA_UNKNOWN = {63{1'b1}};
    localparam logic [62:0] ETA_SAT = 63'h3FFF_FFFF_FFFF_FFFF;
    localparam int WATCHDOG_LIMIT = 20000;

    logic clk;
    logic rst_n;
    logic s_tvalid;
    logic s_tready;
    logic [79:0] s_tdata;
    logic [1:0] s_tuser;
    logic m_tvalid;
    logic m_tready;
    logic [199:0] m_tdata;
    logic cfg_we;
    logic cfg_addr;
    logic [wse_pkg::CFG_W-1:0] cfg_data;

    windowed_speed_eta_estimator DUT
    (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .cfg_we(cfg_we),
        .cfg_addr(cfg_addr),
        .cfg_data(cfg_data)
    );

    // Predictor state.
    logic [31:0] ring_model [wse_pkg::MAX_WINDOW];
    int unsigned head_model;
    int unsigned count_model;
    logic [36:0] sum_model;
    logic [5:0] window_model;
    logic [16:0] alpha_model;

    speed_word_t pending_words [$];
    estimate_t expected_estimates [$];
    int errors;
    int idle_cycles;
    int burst_left;
    int gap_left;
    int stall_phase;
    bit cfg_req;
    logic cfg_req_addr;
    logic [wse_pkg::CFG_W-1:0] cfg_req_data;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic logic [62:0] eta_quotient(logic [47:0] remaining, logic [47:0] speed);
        logic [127:0] numer;
        logic [127:0] quot;
        numer = ({80'd0, remaining} * 128'd1000) << 16;
        quot = numer / {80'd0, speed};
        if (quot > {65'd0, ETA_SAT})
            return ETA_SAT;
        return quot[62:0];
    endfunction

    function automatic estimate_t predict_estimate(speed_word_t w);
        estimate_t e;
        int unsigned eff;
        int unsigned slot;
        logic [16:0] alpha;
        logic [63:0] smooth;
        logic [63:0] avg;
        bit drop;
        eff = (window_model == 0) ? 1 : ((window_model > wse_pkg::MAX_WINDOW) ?
            wse_pkg::MAX_WINDOW : window_model);
        if (w.opcode == wse_pkg::OP_PUSH)
        begin
            slot = (head_model + count_model) % wse_pkg::MAX_WINDOW;
            drop = (count_model >= wse_pkg::MAX_WINDOW) || (count_model + 1 > eff);
            sum_model = sum_model + w.sample_speed;
            if (drop)
            begin
                sum_model = sum_model - ring_model[head_model];
                head_model = (head_model + 1) % wse_pkg::MAX_WINDOW;
            end
            else
                count_model++;
            ring_model[slot] = w.sample_speed;
        end
        else if (w.opcode == wse_pkg::OP_CLEAR)
        begin
            count_model = 0;
            head_model = 0;
            sum_model = '0;
        end
        e = '0;
        e.eta_ms = ETA_UNKNOWN;
        if (count_model > 0)
        begin
            alpha = (alpha_model > wse_pkg::ONE_Q16) ? wse_pkg::ONE_Q16 : alpha_model;
            avg = ({27'd0, sum_model} << 16) / count_model;
            smooth = {16'd0, ring_model[head_model], 16'd0};
            for (int k = 1; k < count_model; k++)
                smooth = alpha * ring_model[(head_model + k) % wse_pkg::MAX_WINDOW]
                    + (((64'd65536 - alpha) * smooth) >> 16);
            e.average_speed = avg[47:0];
            e.smoothed_speed = smooth[47:0];
            e.current_speed =
                ring_model[(head_model + count_model - 1) % wse_pkg::MAX_WINDOW];
            if (smooth != 0 && w.remaining_bytes != 0)
                e.eta_ms = eta_quotient(w.remaining_bytes, smooth[47:0]);
        end
        e.sample_count = count_model[5:0];
        return e;
    endfunction

    // Driver.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tuser <= '0;
            burst_left <= 0;
            gap_left <= 0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (gap_left > 0)
            begin
                s_tvalid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (pending_words.size() > 0)
            begin
                speed_word_t w;
                w = pending_words[0];
                pending_words.delete(0);
                expected_estimates.insert(expected_estimates.size(), predict_estimate(w));
                s_tvalid <= 1'b1;
                s_tuser <= w.opcode;
                s_tdata <= {w.remaining_bytes, w.sample_speed};
                if (burst_left == 0)
                begin
                    burst_left <= $urandom_range(1, 12);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Receiver stall pattern and configuration writes.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            stall_phase <= 0;
            cfg_we <= 1'b0;
            cfg_addr <= 1'b0;
            cfg_data <= '0;
        end
        else
        begin
            stall_phase <= (stall_phase + 1) % 97;
            if (stall_phase < 40)
                m_tready <= 1'b1;
            else if (stall_phase < 70)
                m_tready <= ($urandom_range(0, 2) != 0);
            else
                m_tready <= ($urandom_range(0, 1) != 0) && (stall_phase % 5 != 0);
            cfg_we <= cfg_req;
            cfg_addr <= cfg_req_addr;
            cfg_data <= cfg_req_data;
        end
    end

    // Monitor.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready || m_tvalid && m_tready)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (m_tvalid && m_tready)
            begin
                estimate_t got;
                estimate_t want;
                got = m_tdata[196:0];
                if (expected_estimates.size() == 0)
                begin
                    $error("unexpected word %h", m_tdata);
                    errors++;
                end
                else
                begin
                    want = expected_estimates[0];
                    expected_estimates.delete(0);
                    if (got.average_speed !== want.average_speed)
                    begin
                        $error("average_speed expected %h got %h", want.average_speed,
                            got.average_speed);
                        errors++;
                    end
                    if (got.smoothed_speed !== want.smoothed_speed)
                    begin
                        $error("smoothed_speed expected %h got %h", want.smoothed_speed,
                            got.smoothed_speed);
                        errors++;
                    end
                    if (got.current_speed !== want.current_speed)
                    begin
                        $error("current_speed expected %h got %h", want.current_speed,
                            got.current_speed);
                        errors++;
                    end
                    if (got.eta_ms !== want.eta_ms)
                    begin
                        $error("eta_ms expected %h got %h", want.eta_ms, got.eta_ms);
                        errors++;
                    end
                    if (got.sample_count !== want.sample_count)
                    begin
                        $error("sample_count expected %0d got %0d", want.sample_count,
                            got.sample_count);
                        errors++;
                    end
                    if (m_tdata[199:197] !== 3'b000)
                    begin
                        $error("fill expected 0 got %b", m_tdata[199:197]);
                        errors++;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && idle_cycles > WATCHDOG_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic queue_word(logic [1:0] op, logic [31:0] spd, logic [47:0] rem);
        speed_word_t w;
        w.opcode = op;
        w.sample_speed = spd;
        w.remaining_bytes = rem;
        pending_words.insert(pending_words.size(), w);
    endtask

    task automatic drain;
        while (pending_words.size() > 0 || expected_estimates.size() > 0 || s_tvalid)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic write_register(logic addr, logic [wse_pkg::CFG_W-1:0] value);
        @(posedge clk);
        cfg_req <= 1'b1;
        cfg_req_addr <= addr;
        cfg_req_data <= value;
        if (addr == wse_pkg::CFG_ALPHA)
            alpha_model = value;
        else
            window_model = value[5:0];
        @(posedge clk);
        cfg_req <= 1'b0;
        repeat (3) @(posedge clk);
    endtask

    function automatic logic [31:0] random_speed();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(1, 100);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [47:0] random_remaining();
        case ($urandom_range(0, 5))
            0: return 48'd0;
            1: return 48'hFFFF_FFFF_FFFF;
            2: return {16'd0, $urandom} >> $urandom_range(0, 31);
            default: return 48'({$urandom, $urandom} >> $urandom_range(0, 16));
        endcase
    endfunction

    task automatic queue_random(int count);
        for (int i = 0; i < count; i++)
        begin
            int r;
            logic [1:0] op;
            r = $urandom_range(0, 99);
            op = (r < 75) ? wse_pkg::OP_PUSH : (r < 81) ? wse_pkg::OP_CLEAR :
                (r < 94) ? OP_QUERY : OP_SPARE;
            queue_word(op, random_speed(), random_remaining());
        end
    endtask

    initial
    begin
        int alpha_set [6];
        int window_set [6];
        errors = 0;
        idle_cycles = 0;
        cfg_req = 1'b0;
        cfg_req_addr = 1'b0;
        cfg_req_data = '0;
        head_model = 0;
        count_model = 0;
        sum_model = '0;
        window_model = 6'd32;
        alpha_model = 17'd6554;
        for (int i = 0; i < wse_pkg::MAX_WINDOW; i++)
            ring_model[i] = '0;
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed: empty window, extremes, saturation, zero speed, spare opcode.
        queue_word(OP_QUERY, 32'd5, 48'd100);
        queue_word(OP_SPARE, 32'd7, 48'hFFFF_FFFF_FFFF);
        queue_word(wse_pkg::OP_PUSH, 32'd0, 48'd1000);
        queue_word(wse_pkg::OP_PUSH, 32'd1, 48'hFFFF_FFFF_FFFF);
        queue_word(wse_pkg::OP_PUSH, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
        queue_word(wse_pkg::OP_PUSH, 32'hFFFF_FFFF, 48'd0);
        queue_word(OP_QUERY, 32'd0, 48'd1);
        queue_word(wse_pkg::OP_CLEAR, 32'hFFFF_FFFF, 48'd12345);
        queue_word(wse_pkg::OP_PUSH, 32'd1, 48'hFFFF_FFFF_FFFF);
        queue_word(wse_pkg::OP_CLEAR, 32'd0, 48'd0);
        for (int i = 0; i < 34; i++)
            queue_word(wse_pkg::OP_PUSH, (i % 2) ? 32'hFFFF_FFFF : 32'(i), 48'd777 * i);
        drain();

        // Window shrunk while full, then out-of-range settings.
        write_register(wse_pkg::CFG_WINDOW, 17'd4);
        queue_random(10);
        drain();
        write_register(wse_pkg::CFG_WINDOW, 17'd0);
        write_register(wse_pkg::CFG_ALPHA, 17'h1FFFF);
        queue_word(wse_pkg::OP_CLEAR, 32'd0, 48'd1);
        queue_random(10);
        drain();

        alpha_set = '{0, 65536, 1, 32768, 6554, 100000};
        window_set = '{1, 32, 63, 2, 17, 8};
        for (int p = 0; p < 6; p++)
        begin
            write_register(wse_pkg::CFG_ALPHA, 17'(alpha_set[p]));
            write_register(wse_pkg::CFG_WINDOW, 17'(window_set[p]));
            queue_random(210);
            drain();
        end
        write_register(wse_pkg::CFG_WINDOW, 17'd32);
        write_register(wse_pkg::CFG_ALPHA, 17'd6554);
        queue_random(60);
        drain();

        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire
